[sv/stok_pkg.sv]
// Package with shared types, constants and classification functions for the source tokenizer.
package stok_pkg;

   localparam int LINE_BITS_DEF = 16;
   localparam int KIND_W = 5;
   localparam int OUT_LINE_W = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   localparam logic [KIND_W-1:0] K_END     = 5'd0;
   localparam logic [KIND_W-1:0] K_IDENT   = 5'd1;
   localparam logic [KIND_W-1:0] K_NUMBER  = 5'd2;
   localparam logic [KIND_W-1:0] K_STRING  = 5'd3;
   localparam logic [KIND_W-1:0] K_DIV     = 5'd14;
   localparam logic [KIND_W-1:0] K_UNKNOWN = 5'd26;

   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_BAR   = 8'h7C;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_T     = 8'h74;

   typedef enum logic [3:0] {
      M_IDLE, M_SLASH, M_COMMENT, M_IDENT, M_NUM_INT, M_NUM_FRAC, M_STR, M_STR_ESC, M_PAIR
   } mode_type;

   // One result of the tokenizer.
   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic [7:0]            text;
      logic                  text_valid;
      logic                  last;
      logic [OUT_LINE_W-1:0] line;
   } result_type;

   // Up to three result slots; one request produces at most two results.
   typedef struct packed {
      logic [1:0]  count;
      result_type  r0;
      result_type  r1;
      result_type  r2;
   } bundle_type;

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_ident_start(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_pair_start(input logic [7:0] c);
      return c == CH_EQ || c == 8'h21 || c == 8'h3C || c == 8'h3E || c == CH_AMP || c == CH_BAR;
   endfunction

   function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] c);
      case (c)
         8'h28: return 5'd4;
         8'h29: return 5'd5;
         8'h7B: return 5'd6;
         8'h7D: return 5'd7;
         8'h2C: return 5'd8;
         8'h3B: return 5'd9;
         8'h2E: return 5'd10;
         8'h2B: return 5'd11;
         8'h2D: return 5'd12;
         8'h2A: return 5'd13;
         8'h25: return 5'd15;
         default: return K_UNKNOWN;
      endcase
   endfunction

   function automatic logic [KIND_W-1:0] pair_alone(input logic [7:0] c);
      case (c)
         8'h3D: return 5'd16;
         8'h21: return 5'd18;
         8'h3C: return 5'd20;
         8'h3E: return 5'd22;
         default: return K_UNKNOWN;
      endcase
   endfunction

   function automatic logic [KIND_W-1:0] pair_double(input logic [7:0] c);
      case (c)
         8'h3D: return 5'd17;
         8'h21: return 5'd19;
         8'h3C: return 5'd21;
         8'h3E: return 5'd23;
         8'h26: return 5'd24;
         default: return 5'd25;
      endcase
   endfunction

endpackage

[sv/stok_front.sv]
// Front end: the scanner state machine that turns each request into a bundle of results.
module stok_front #(
   parameter int LINE_BITS = stok_pkg::LINE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [7:0]             in_byte,
   input  logic                   in_end,
   output logic                   bnd_valid,
   input  logic                   bnd_ready,
   output stok_pkg::bundle_type   bnd_data
);

   localparam logic [LINE_BITS-1:0] LINE_TOP = {LINE_BITS{1'b1}};
   localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
   localparam int OUT_W = stok_pkg::OUT_LINE_W;

   stok_pkg::mode_type     mode_ff, mode_in;
   logic [7:0]             held_char_ff, held_char_in;
   logic                   held_present_ff, held_present_in;
   logic [stok_pkg::KIND_W-1:0] held_kind_ff, held_kind_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [LINE_BITS-1:0]   tok_line_ff, tok_line_in;
   logic [OUT_W-1:0]       line_out, tok_line_out;
   stok_pkg::bundle_type   bnd;
   logic                   take;

   assign in_ready  = bnd_ready;
   assign bnd_valid = in_valid;
   assign bnd_data  = bnd;
   assign take      = in_valid && bnd_ready;
   assign line_out     = OUT_W'(line_ff);
   assign tok_line_out = OUT_W'(tok_line_ff);

   always_comb begin
      logic [1:0]        n;
      stok_pkg::result_type r [3];
      logic              rescan;
      logic [7:0]        c;
      logic [7:0]        ec;
      n = 2'd0;
      for (int i = 0; i < 3; i++) begin
         r[i] = '0;
      end
      rescan = 1'b0;
      c = in_byte;
      ec = c;
      mode_in = mode_ff;
      held_char_in = held_char_ff;
      held_present_in = held_present_ff;
      held_kind_in = held_kind_ff;
      line_in = line_ff;
      tok_line_in = tok_line_ff;

      if (in_end) begin
         case (mode_ff)
            stok_pkg::M_IDENT, stok_pkg::M_NUM_INT, stok_pkg::M_NUM_FRAC, stok_pkg::M_SLASH,
            stok_pkg::M_PAIR: begin
               r[0] = '{held_kind_ff, held_char_ff, 1'b1, 1'b1, tok_line_out};
               n = 2'd1;
            end
            stok_pkg::M_STR, stok_pkg::M_STR_ESC: begin
               r[0] = '{stok_pkg::K_STRING, held_present_ff ? held_char_ff : 8'd0,
                        held_present_ff, 1'b1, tok_line_out};
               n = 2'd1;
            end
            default: ;
         endcase
         r[n] = '{stok_pkg::K_END, 8'd0, 1'b0, 1'b1, line_out};
         n = n + 2'd1;
         mode_in = stok_pkg::M_IDLE;
         held_char_in = 8'd0;
         held_present_in = 1'b0;
         held_kind_in = '0;
         line_in = LINE_ONE;
         tok_line_in = LINE_ONE;
      end else begin
         case (mode_ff)
            stok_pkg::M_SLASH: begin
               if (c == stok_pkg::CH_SLASH) begin
                  held_present_in = 1'b0;
                  mode_in = stok_pkg::M_COMMENT;
               end else begin
                  r[0] = '{held_kind_ff, held_char_ff, 1'b1, 1'b1, tok_line_out};
                  n = 2'd1;
                  rescan = 1'b1;
               end
            end
            stok_pkg::M_COMMENT: begin
               if (c == stok_pkg::CH_LF) begin
                  rescan = 1'b1;
               end
            end
            stok_pkg::M_IDENT, stok_pkg::M_NUM_INT, stok_pkg::M_NUM_FRAC: begin
               if ((mode_ff == stok_pkg::M_IDENT &&
                    (stok_pkg::is_ident_start(c) || stok_pkg::is_digit(c))) ||
                   (mode_ff != stok_pkg::M_IDENT && stok_pkg::is_digit(c)) ||
                   (mode_ff == stok_pkg::M_NUM_INT && c == stok_pkg::CH_DOT)) begin
                  r[0] = '{held_kind_ff, held_char_ff, 1'b1, 1'b0, tok_line_out};
                  n = 2'd1;
                  held_char_in = c;
                  if (c == stok_pkg::CH_DOT) begin
                     mode_in = stok_pkg::M_NUM_FRAC;
                  end
               end else begin
                  r[0] = '{held_kind_ff, held_char_ff, 1'b1, 1'b1, tok_line_out};
                  n = 2'd1;
                  rescan = 1'b1;
               end
            end
            stok_pkg::M_STR, stok_pkg::M_STR_ESC: begin
               if (mode_ff == stok_pkg::M_STR &&
                   (c == stok_pkg::CH_QUOTE || c == stok_pkg::CH_LF)) begin
                  r[0] = '{stok_pkg::K_STRING, held_present_ff ? held_char_ff : 8'd0,
                           held_present_ff, 1'b1, tok_line_out};
                  n = 2'd1;
                  held_present_in = 1'b0;
                  mode_in = stok_pkg::M_IDLE;
                  rescan = (c == stok_pkg::CH_LF);
               end else if (mode_ff == stok_pkg::M_STR && c == stok_pkg::CH_BSL) begin
                  mode_in = stok_pkg::M_STR_ESC;
               end else begin
                  if (mode_ff == stok_pkg::M_STR_ESC) begin
                     ec = (c == stok_pkg::CH_N) ? stok_pkg::CH_LF :
                          (c == stok_pkg::CH_T) ? stok_pkg::CH_TAB : c;
                  end
                  if (held_present_ff) begin
                     r[0] = '{stok_pkg::K_STRING, held_char_ff, 1'b1, 1'b0,
                              tok_line_out};
                     n = 2'd1;
                  end
                  held_char_in = ec;
                  held_present_in = 1'b1;
                  held_kind_in = stok_pkg::K_STRING;
                  mode_in = stok_pkg::M_STR;
               end
            end
            stok_pkg::M_PAIR: begin
               if (c == (((held_char_ff == stok_pkg::CH_AMP) ||
                          (held_char_ff == stok_pkg::CH_BAR)) ? held_char_ff : stok_pkg::CH_EQ)) begin
                  r[0] = '{stok_pkg::pair_double(held_char_ff), held_char_ff, 1'b1, 1'b0,
                           tok_line_out};
                  r[1] = '{stok_pkg::pair_double(held_char_ff), c, 1'b1, 1'b1,
                           tok_line_out};
                  n = 2'd2;
                  held_present_in = 1'b0;
                  mode_in = stok_pkg::M_IDLE;
               end else begin
                  r[0] = '{held_kind_ff, held_char_ff, 1'b1, 1'b1, tok_line_out};
                  n = 2'd1;
                  rescan = 1'b1;
               end
            end
            default: rescan = 1'b1;
         endcase

         if (rescan) begin
            mode_in = stok_pkg::M_IDLE;
            held_present_in = 1'b0;
            if (stok_pkg::is_space(c)) begin
               if (c == stok_pkg::CH_LF && line_ff != LINE_TOP) begin
                  line_in = line_ff + LINE_ONE;
               end
            end else if (c == stok_pkg::CH_QUOTE) begin
               tok_line_in = line_ff;
               mode_in = stok_pkg::M_STR;
            end else if (c == stok_pkg::CH_SLASH || stok_pkg::is_ident_start(c) ||
                         stok_pkg::is_digit(c) || stok_pkg::is_pair_start(c)) begin
               tok_line_in = line_ff;
               held_char_in = c;
               held_present_in = 1'b1;
               if (c == stok_pkg::CH_SLASH) begin
                  mode_in = stok_pkg::M_SLASH;
                  held_kind_in = stok_pkg::K_DIV;
               end else if (stok_pkg::is_ident_start(c)) begin
                  mode_in = stok_pkg::M_IDENT;
                  held_kind_in = stok_pkg::K_IDENT;
               end else if (stok_pkg::is_digit(c)) begin
                  mode_in = stok_pkg::M_NUM_INT;
                  held_kind_in = stok_pkg::K_NUMBER;
               end else begin
                  mode_in = stok_pkg::M_PAIR;
                  held_kind_in = stok_pkg::pair_alone(c);
               end
            end else begin
               tok_line_in = line_ff;
               r[n] = '{stok_pkg::single_kind(c), c, 1'b1, 1'b1, line_out};
               n = n + 2'd1;
            end
         end
      end
      bnd.count = n;
      bnd.r0 = r[0];
      bnd.r1 = r[1];
      bnd.r2 = r[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= stok_pkg::M_IDLE;
         held_char_ff <= 8'd0;
         held_present_ff <= 1'b0;
         held_kind_ff <= '0;
         line_ff <= LINE_ONE;
         tok_line_ff <= LINE_ONE;
      end else if (take) begin
         mode_ff <= mode_in;
         held_char_ff <= held_char_in;
         held_present_ff <= held_present_in;
         held_kind_ff <= held_kind_in;
         line_ff <= line_in;
         tok_line_ff <= tok_line_in;
      end
   end

   a_line_nonzero: assert property (@(posedge clock) disable iff (reset) line_ff != '0)
      else $error("line counter reached zero");
   a_end_resets: assert property (@(posedge clock) disable iff (reset)
      take && in_end |=> mode_ff == stok_pkg::M_IDLE && line_ff == LINE_ONE)
      else $error("end of source did not restart the scanner");
   a_comment_silent: assert property (@(posedge clock) disable iff (reset)
      take && !in_end && mode_ff == stok_pkg::M_COMMENT |-> bnd.count == 2'd0)
      else $error("comment produced a result");

endmodule

[sv/stok_back.sv]
// Back end: a short bundle queue and a sequencer that delivers the results one at a time.
module stok_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   bnd_valid,
   output logic                   bnd_ready,
   input  stok_pkg::bundle_type   bnd_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output stok_pkg::result_type   out_data
);

   stok_pkg::bundle_type q_ff [stok_pkg::QUEUE_DEPTH];
   logic [stok_pkg::QUEUE_PTR_W-1:0] wr_ff, rd_ff;
   logic [stok_pkg::QUEUE_PTR_W:0]   cnt_ff, cnt_in;
   logic [1:0]                       sub_ff, sub_in;
   stok_pkg::bundle_type             head;
   logic                             push, pop, out_take;

   // Bundles with no results never enter the queue.
   assign bnd_ready = cnt_ff != 3'(stok_pkg::QUEUE_DEPTH);
   assign push      = bnd_valid && bnd_ready && bnd_data.count != 2'd0;
   assign head      = q_ff[rd_ff];
   assign out_valid = cnt_ff != '0;
   assign out_take  = out_valid && out_ready;
   assign pop       = out_take && (sub_ff + 2'd1 == head.count);

   always_comb begin
      case (sub_ff)
         2'd0: out_data = head.r0;
         2'd1: out_data = head.r1;
         default: out_data = head.r2;
      endcase
      sub_in = out_take ? (pop ? 2'd0 : sub_ff + 2'd1) : sub_ff;
      cnt_in = cnt_ff + {2'b0, push} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= bnd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
         sub_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         cnt_ff <= cnt_in;
         sub_ff <= sub_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(stok_pkg::QUEUE_DEPTH))
      else $error("queue count out of range");
   a_sub_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> sub_ff < head.count)
      else $error("result index beyond bundle");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == '0 |-> !pop && sub_ff == 2'd0)
      else $error("pop from an empty queue");

endmodule

[sv/source_tokenizer_top.sv]
// Top level of the source tokenizer: scanner front end feeding a queued result back end.
// The block takes one source byte per cycle while the queue has room, and gives one result
// per token character, or one empty result for an empty string or END; a request yields
// zero to two results, so the output delivers results at one per cycle while rsp_tready is
// high, and a request that makes two results can hold the input once the four-entry bundle
// queue between scanner and output fills. A request's first result is queued when it is
// taken and offered after any results ahead. Identifier and number characters appear one
// byte later than they arrive, since the next byte decides which one ends the token.
module source_tokenizer_top #(
   parameter int LINE_BITS = stok_pkg::LINE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // src_byte
   input  logic        req_tlast,  // end_of_source
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // token_kind[4:0], text_byte[12:5], text_valid[13],
                                   // start_line[29:14], zero[31:30]
   output logic        rsp_tlast   // token_last
);

   logic                 bnd_valid, bnd_ready;
   stok_pkg::bundle_type bnd_data;
   stok_pkg::result_type res;

   stok_front #(.LINE_BITS(LINE_BITS)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_byte(req_tdata), .in_end(req_tlast),
      .bnd_valid(bnd_valid), .bnd_ready(bnd_ready), .bnd_data(bnd_data)
   );

   stok_back u_back (
      .clock(clock), .reset(reset),
      .bnd_valid(bnd_valid), .bnd_ready(bnd_ready), .bnd_data(bnd_data),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(res)
   );

   assign rsp_tdata = {2'b00, res.line, res.text_valid, res.text, res.kind};
   assign rsp_tlast = res.last;

endmodule
